// ----- hdl/sorted_key_table_macros.svh -----
// ----------------------------------------------------------------------------
// sorted key table assertion macros
// shared concurrent assertion forms, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// same-cycle implication
`define SKT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// sorted key table package
// field widths, opcode and status codes, sequencer state codes, default capacity
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int CapacityDefault = 64;
   localparam int KeyWidth        = 31;
   localparam int PosWidth        = 6;
   localparam int CntWidth        = 7;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2,
      ST_RSVD = 2'd3
   } status_type;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SRCH    = 7'b0000010,
      S_SCMP    = 7'b0000100,
      S_PROBE   = 7'b0001000,
      S_PCHK    = 7'b0010000,
      S_MOVE    = 7'b0100000,
      S_MOVE_WR = 7'b1000000
   } state_type;

endpackage

// ----- hdl/sorted_key_table.sv -----
// sequence: binary search steps over the filled entries, each a ram read and a key compare,
//   then the closing bound check and exact-match probe; a completed insert or remove then
//   shifts entries by a read and a write each, and an insert writes its new entry last
// one request at a time; busy falls in the cycle of the result strobe
// the single ram port pair and the key comparisons set this sequence; no receiver stall
// reset clears the entry count and the sequencer; ram contents are not cleared
// ----------------------------------------------------------------------------
// sorted key table
// ascending key table with lookup, insert and remove over a shared ram
// ----------------------------------------------------------------------------
module sorted_key_table
   import skt_pkg::*;
#(
   parameter int CAPACITY = CapacityDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic [KeyWidth-1:0] req_key,
   input  logic [KeyWidth-1:0] req_payload,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [KeyWidth-1:0] rsp_found_key,
   output logic [KeyWidth-1:0] rsp_found_payload,
   output logic [PosWidth-1:0] rsp_position,
   output logic [CntWidth-1:0] rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = 2 * KeyWidth;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       mv_idx_ff, mv_idx_in;
   logic                probe_ok_ff, probe_ok_in;
   opcode_type          op_ff, op_in;
   logic [KeyWidth-1:0] key_ff, key_in;
   logic [KeyWidth-1:0] pay_ff, pay_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          res_status_ff, res_status_in;
   logic [KeyWidth-1:0] res_pay_ff, res_pay_in;
   logic [CW-1:0]       res_pos_ff, res_pos_in;

   logic [CW-1:0]       mid;
   logic [CW-1:0]       rd_idx;
   logic [CW-1:0]       wr_idx;
   logic                wr_en;
   logic [DW-1:0]       wr_data;
   logic [DW-1:0]       rd_data;
   logic [KeyWidth-1:0] rd_key;
   logic [KeyWidth-1:0] rd_pay;
   logic                hit;
   logic [31:0]         pos_wide;
   logic [31:0]         cnt_wide;

   skt_ram #(
      .WIDTH(DW),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_idx[AW-1:0]),
      .wr_data(wr_data),
      .rd_addr(rd_idx[AW-1:0]),
      .rd_data(rd_data)
   );

   assign rd_key = rd_data[DW-1:KeyWidth];
   assign rd_pay = rd_data[KeyWidth-1:0];
   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign hit    = probe_ok_ff && (rd_key == key_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mv_idx_in     = mv_idx_ff;
      probe_ok_in   = probe_ok_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      rsp_valid_in  = 1'b0;
      res_status_in = res_status_ff;
      res_pay_in    = res_pay_ff;
      res_pos_in    = res_pos_ff;
      rd_idx        = lo_ff;
      wr_idx        = mv_idx_ff;
      wr_en         = 1'b0;
      wr_data       = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = opcode_type'(req_opcode);
               key_in   = req_key;
               pay_in   = req_payload;
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            rd_idx = mid;
            if (lo_ff < hi_ff) begin
               state_in = S_SCMP;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_SCMP: begin
            if (rd_key < key_ff) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = S_SRCH;
         end
         S_PROBE: begin
            rd_idx      = lo_ff;
            probe_ok_in = (lo_ff < count_ff);
            state_in    = S_PCHK;
         end
         S_PCHK: begin
            res_status_in = ST_MISS;
            res_pay_in    = '0;
            res_pos_in    = '0;
            case (op_ff)
               OP_LOOKUP: begin
                  if (hit) begin
                     res_status_in = ST_DONE;
                     res_pay_in    = rd_pay;
                     res_pos_in    = lo_ff;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               OP_INSERT: begin
                  if (hit) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else if (count_ff == CW'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     res_status_in = ST_DONE;
                     res_pay_in    = pay_ff;
                     res_pos_in    = lo_ff;
                     mv_idx_in     = count_ff;
                     state_in      = S_MOVE;
                  end
               end
               OP_REMOVE: begin
                  if (hit) begin
                     res_status_in = ST_DONE;
                     res_pay_in    = rd_pay;
                     res_pos_in    = lo_ff;
                     mv_idx_in     = lo_ff;
                     state_in      = S_MOVE;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_MOVE: begin
            if (op_ff == OP_INSERT) begin
               rd_idx = mv_idx_ff - CW'(1);
               if (mv_idx_ff > lo_ff) begin
                  state_in = S_MOVE_WR;
               end else begin
                  wr_en        = 1'b1;
                  wr_idx       = lo_ff;
                  wr_data      = {key_ff, pay_ff};
                  count_in     = count_ff + CW'(1);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               rd_idx = mv_idx_ff + CW'(1);
               if ((mv_idx_ff + CW'(1)) < count_ff) begin
                  state_in = S_MOVE_WR;
               end else begin
                  count_in     = count_ff - CW'(1);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         S_MOVE_WR: begin
            wr_en  = 1'b1;
            wr_idx = mv_idx_ff;
            if (op_ff == OP_INSERT) begin
               mv_idx_in = mv_idx_ff - CW'(1);
            end else begin
               mv_idx_in = mv_idx_ff + CW'(1);
            end
            state_in = S_MOVE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mv_idx_ff     <= mv_idx_in;
      probe_ok_ff   <= probe_ok_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      res_status_ff <= res_status_in;
      res_pay_ff    <= res_pay_in;
      res_pos_ff    <= res_pos_in;
   end

   assign pos_wide = 32'(res_pos_ff);
   assign cnt_wide = 32'(count_ff);

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = res_status_ff;
   assign rsp_found_key     = key_ff;
   assign rsp_found_payload = res_pay_ff;
   assign rsp_position      = pos_wide[PosWidth-1:0];
   assign rsp_entry_count   = cnt_wide[CntWidth-1:0];

`include "sorted_key_table_macros.svh"

   `SKT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(CAPACITY), "count above capacity")
   `SKT_ASSERT_NOW(a_full_only_at_cap, rsp_valid && (rsp_status == ST_FULL), count_ff == CW'(CAPACITY), "full status below capacity")
   `SKT_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
   `SKT_ASSERT_NOW(a_done_zero_pay, rsp_valid && (rsp_status != ST_DONE), rsp_found_payload == '0 && rsp_position == '0, "not-done word carries data")

endmodule

// ----- hdl/skt_ram.sv -----
// ----------------------------------------------------------------------------
// sorted key table ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module skt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/sv/tb_sorted_key_table.sv -----
// ----------------------------------------------------------------------------
// sorted key table testbench
// issues lookup, insert, remove and unused-opcode words against a predicted copy of the
// table, runs it through empty, full and overflow, and checks every result
// word field by field
// ----------------------------------------------------------------------------
module tb_sorted_key_table
   import skt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int Capacity   = CapacityDefault;
   localparam int PoolSize   = 96;
   localparam int CycleLimit = 1000000;
   localparam int DrainWait  = 300;

   typedef struct {
      opcode_type          op;
      logic [KeyWidth-1:0] key;
      logic [KeyWidth-1:0] payload;
      int                  gap;
      bit                  drain;
   } req_word_type;

   typedef struct {
      status_type          status;
      logic [KeyWidth-1:0] key;
      logic [KeyWidth-1:0] payload;
      logic [PosWidth-1:0] pos;
      logic [CntWidth-1:0] count;
   } rsp_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_opcode = '0;
   logic [KeyWidth-1:0] req_key = '0;
   logic [KeyWidth-1:0] req_payload = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [KeyWidth-1:0] rsp_found_key;
   logic [KeyWidth-1:0] rsp_found_payload;
   logic [PosWidth-1:0] rsp_position;
   logic [CntWidth-1:0] rsp_entry_count;

   sorted_key_table uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_found_key     (rsp_found_key),
      .rsp_found_payload (rsp_found_payload),
      .rsp_position      (rsp_position),
      .rsp_entry_count   (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted table contents
   logic [KeyWidth-1:0] table_keys [Capacity];
   logic [KeyWidth-1:0] table_pays [Capacity];
   int                  table_fill = 0;
   int                  peak_fill = 0;
   int                  n_done = 0;
   int                  n_miss = 0;
   int                  n_full = 0;

   req_word_type        pending_reqs [$];
   rsp_word_type        expected_rsps [$];
   logic [KeyWidth-1:0] key_pool [PoolSize];
   bit                  burst_mode = 0;
   int                  n_accepted = 0;
   int                  n_returned = 0;
   int                  errors = 0;
   int                  cycles = 0;

   function automatic rsp_word_type apply_request(req_word_type rq);
      rsp_word_type r;
      int           lb;
      bit           hit;
      r.status  = ST_MISS;
      r.key     = rq.key;
      r.payload = '0;
      r.pos     = '0;
      lb = 0;
      while (lb < table_fill && table_keys[lb] < rq.key) lb++;
      hit = (lb < table_fill) && (table_keys[lb] == rq.key);
      case (rq.op)
         OP_LOOKUP: begin
            if (hit) begin
               r.status  = ST_DONE;
               r.payload = table_pays[lb];
               r.pos     = lb[PosWidth-1:0];
            end
         end
         OP_INSERT: begin
            if (hit) begin
               r.status = ST_MISS;
            end else if (table_fill >= Capacity) begin
               r.status = ST_FULL;
            end else begin
               for (int i = table_fill; i > lb; i--) begin
                  table_keys[i] = table_keys[i-1];
                  table_pays[i] = table_pays[i-1];
               end
               table_keys[lb] = rq.key;
               table_pays[lb] = rq.payload;
               table_fill++;
               r.status  = ST_DONE;
               r.payload = rq.payload;
               r.pos     = lb[PosWidth-1:0];
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               r.status  = ST_DONE;
               r.payload = table_pays[lb];
               r.pos     = lb[PosWidth-1:0];
               for (int i = lb; i + 1 < table_fill; i++) begin
                  table_keys[i] = table_keys[i+1];
                  table_pays[i] = table_pays[i+1];
               end
               table_fill--;
            end
         end
         default: ;
      endcase
      r.count = table_fill[CntWidth-1:0];
      if (table_fill > peak_fill) peak_fill = table_fill;
      case (r.status)
         ST_DONE: n_done++;
         ST_FULL: n_full++;
         default: n_miss++;
      endcase
      return r;
   endfunction

   task automatic add_req(opcode_type op, logic [KeyWidth-1:0] k, logic [KeyWidth-1:0] p,
                          bit drain);
      req_word_type rq;
      rq.op      = op;
      rq.key     = k;
      rq.payload = p;
      rq.gap     = burst_mode ? 0 : $urandom_range(0, 10);
      rq.drain   = drain;
      pending_reqs.push_back(rq);
   endtask

   task automatic report(string field, logic [31:0] exp_val, logic [31:0] act_val);
      errors++;
      $display("%0t mismatch on %s: expected %0h, actual %0h",
               $time, field, exp_val, act_val);
   endtask

   // driver
   req_word_type cur;
   bit           have_cur = 0;
   int           gap_left = 0;
   bit           go;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(apply_request(cur));
            n_accepted++;
            have_cur = 0;
         end
         if (!start || !busy) begin
            if (!have_cur && pending_reqs.size() > 0) begin
               cur      = pending_reqs.pop_front();
               have_cur = 1;
               gap_left = cur.gap;
            end
            go = 0;
            if (have_cur) begin
               if (gap_left > 0)
                  gap_left--;
               else if (!(cur.drain && n_accepted != n_returned))
                  go = 1;
            end
            start <= go;
            if (go) begin
               req_opcode  <= cur.op;
               req_key     <= cur.key;
               req_payload <= cur.payload;
            end
         end
      end
   end

   // monitor
   rsp_word_type got;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t unexpected result word: status %0h key %0h",
                     $time, rsp_status, rsp_found_key);
         end else begin
            got = expected_rsps.pop_front();
            n_returned <= n_returned + 1;
            if (rsp_status !== got.status)
               report("status", 32'(got.status), 32'(rsp_status));
            if (rsp_found_key !== got.key)
               report("found_key", 32'(got.key), 32'(rsp_found_key));
            if (rsp_found_payload !== got.payload)
               report("found_payload", 32'(got.payload), 32'(rsp_found_payload));
            if (rsp_position !== got.pos)
               report("position", 32'(got.pos), 32'(rsp_position));
            if (rsp_entry_count !== got.count)
               report("entry_count", 32'(got.count), 32'(rsp_entry_count));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycles, n_accepted - n_returned);
         $display("tb_sorted_key_table: FAIL");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int  n;
      int  seg;
      int  sel;
      bit  fresh;
      logic [KeyWidth-1:0] k;
      opcode_type op;

      // distinct key pool with extremes and a tight cluster
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 31'd1;
      key_pool[3] = 31'h7FFFFFFE;
      for (int i = 4; i < 16; i++) key_pool[i] = KeyWidth'(31'h40000000 + i);
      for (int i = 16; i < PoolSize; i++) begin
         fresh = 0;
         while (!fresh) begin
            k = KeyWidth'($urandom());
            fresh = 1;
            for (int j = 0; j < i; j++) if (key_pool[j] == k) fresh = 0;
         end
         key_pool[i] = k;
      end

      // directed words
      add_req(OP_LOOKUP, 31'd5, 31'd9, 0);
      add_req(OP_REMOVE, 31'd5, 31'd9, 0);
      add_req(OP_UNUSED, 31'd5, 31'd9, 0);
      add_req(OP_INSERT, '1, '0, 0);
      add_req(OP_INSERT, '0, '1, 0);
      add_req(OP_INSERT, 31'h2AAAAAAA, 31'h55555555, 0);
      add_req(OP_INSERT, 31'h55555555, 31'h2AAAAAAA, 0);
      add_req(OP_INSERT, '0, 31'h1234, 0);
      add_req(OP_LOOKUP, '0, '0, 1);
      add_req(OP_LOOKUP, '1, '0, 0);
      add_req(OP_LOOKUP, 31'h2AAAAAAA, '1, 0);
      add_req(OP_LOOKUP, 31'd1, '0, 0);
      add_req(OP_UNUSED, 31'h55555555, '1, 0);
      add_req(OP_REMOVE, 31'h2AAAAAAA, '0, 0);
      add_req(OP_LOOKUP, 31'h2AAAAAAA, '0, 0);
      add_req(OP_REMOVE, '0, '0, 0);
      add_req(OP_REMOVE, '1, '0, 0);
      add_req(OP_REMOVE, 31'h55555555, '0, 0);
      add_req(OP_REMOVE, 31'h55555555, '0, 0);
      add_req(OP_INSERT, '1, '1, 0);

      // fill to capacity and overflow, then a duplicate insert into the full table and a lookup
      for (int i = 0; i < 70; i++)
         add_req(OP_INSERT, key_pool[i], KeyWidth'($urandom()), i == 0);
      add_req(OP_INSERT, key_pool[10], KeyWidth'($urandom()), 0);
      add_req(OP_LOOKUP, key_pool[20], '0, 0);

      // random words, alternating insert-heavy and remove-heavy stretches
      for (int i = 0; i < 1000; i++) begin
         seg        = i / 125;
         burst_mode = (seg % 3 == 0);
         sel        = $urandom_range(0, 99);
         if (sel < 3)
            op = OP_UNUSED;
         else if (sel < 25)
            op = OP_LOOKUP;
         else if (seg % 2 == 0)
            op = (sel < 80) ? OP_INSERT : OP_REMOVE;
         else
            op = (sel < 45) ? OP_INSERT : OP_REMOVE;
         if ($urandom_range(0, 99) < 88)
            k = key_pool[$urandom_range(0, PoolSize - 1)];
         else
            k = KeyWidth'($urandom());
         add_req(op, k, KeyWidth'($urandom()), i % 97 == 96);
      end
      n = pending_reqs.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || have_cur || start || n_returned != n_accepted)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      if (expected_rsps.size() != 0) begin
         errors++;
         $display("%0d expected result words never arrived", expected_rsps.size());
      end
      $display("covered %0d words: %0d done, %0d absent or duplicate, %0d refused as full",
               n, n_done, n_miss, n_full);
      $display("table fill peaked at %0d of %0d entries", peak_fill, Capacity);
      if (errors == 0)
         $display("tb_sorted_key_table: PASS");
      else
         $display("tb_sorted_key_table: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_ram.sv
hdl/sorted_key_table.sv
tb/sv/tb_sorted_key_table.sv
